### design/label_hash_color_blend_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the label hash color blend unit
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LABEL_HASH_COLOR_BLEND_UNIT_ASSERT_SVH
`define LABEL_HASH_COLOR_BLEND_UNIT_ASSERT_SVH

// same-cycle implication
`define LHCB_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lhcb: same-cycle check failed");

// next-cycle implication
`define LHCB_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lhcb: next-cycle check failed");

`endif

### design/lhcb_pkg.sv
// ----------------------------------------------------------------------------
// lhcb_pkg
// Shared types and constants of the label hash color blend unit.
// ----------------------------------------------------------------------------
package lhcb_pkg;

	typedef enum logic [1:0] {
		ACT_REMAP_WR = 2'd0,
		ACT_COLOR_WR = 2'd1,
		ACT_PIXEL    = 2'd2
	} action_t;

	localparam logic [1:0] CFG_REMAP_EN    = 2'd0;
	localparam logic [1:0] CFG_HASH_MASK   = 2'd1;
	localparam logic [1:0] CFG_COLOR_COUNT = 2'd2;

	localparam logic [31:0] GOLDEN_FRAC = 32'h9E37_79B9;
	localparam logic [7:0]  CHAN_MAX    = 8'd255;
	localparam logic [5:0]  COUNT_RESET = 6'd26;
	localparam int          HASH_W      = 6;

	typedef struct packed {
		logic        remap_enable;
		logic [31:0] hash_mask;
		logic [5:0]  color_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [15:0] table_index;
		logic [31:0] entry_value;
		logic [31:0] label;
		logic [7:0]  gray;
	} in_item_t;

	// fields that ride along the hash stages
	typedef struct packed {
		logic        is_pixel;
		logic        use_remap;
		logic        oor;
		logic [7:0]  gray;
		logic [15:0] widx;
		logic [23:0] wval;
	} tag_t;

	typedef struct packed {
		tag_t        tag;
		logic [31:0] label;
	} hash_item_t;

	typedef struct packed {
		tag_t              tag;
		logic [HASH_W-1:0] h;
	} color_item_t;

	typedef struct packed {
		logic       oor;
		logic [7:0] gray;
	} blend_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       oor;
	} result_t;

endpackage

### design/lhcb_cfg_regs.sv
// ----------------------------------------------------------------------------
// lhcb_cfg_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module lhcb_cfg_regs
	import lhcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remap_enable <= 1'b0;
			cfg_q.hash_mask    <= 32'd0;
			cfg_q.color_count  <= COUNT_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_REMAP_EN:    cfg_q.remap_enable <= wr_data[0];
				CFG_HASH_MASK:   cfg_q.hash_mask    <= wr_data;
				CFG_COLOR_COUNT: cfg_q.color_count  <= wr_data[5:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### design/lhcb_remap.sv
// ----------------------------------------------------------------------------
// lhcb_remap
// Remap table memory: writes from load items, registered label lookup.
// ----------------------------------------------------------------------------
`include "label_hash_color_blend_unit_assert.svh"

module lhcb_remap
	import lhcb_pkg::*;
#(
	parameter int REMAP_DEPTH = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        remap_enable,
	input  logic        v_s1,
	input  in_item_t    item_s1,
	output logic        v_s2,
	output hash_item_t  item_s2,
	output logic [31:0] rdata_s2
);

	localparam int RAW = $clog2(REMAP_DEPTH);

	logic [31:0] mem [REMAP_DEPTH];

	logic label_in_range;
	logic idx_in_range;
	logic wr;
	logic rd;
	logic is_pixel;
	logic is_color_wr;

	assign label_in_range = item_s1.label < 32'(REMAP_DEPTH);
	assign idx_in_range   = {16'd0, item_s1.table_index} < 32'(REMAP_DEPTH);
	assign is_pixel       = item_s1.action == ACT_PIXEL;
	assign is_color_wr    = item_s1.action == ACT_COLOR_WR;
	assign wr = v_s1 && (item_s1.action == ACT_REMAP_WR) && idx_in_range;
	assign rd = v_s1 && is_pixel && remap_enable && label_in_range;

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr)
				mem[RAW'(item_s1.table_index)] <= item_s1.entry_value;
			if (rd)
				rdata_s2 <= mem[RAW'(item_s1.label)];
		end
	end

	// remap writes retire here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (en)
			v_s2 <= v_s1 && (is_pixel || is_color_wr);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s2.tag.is_pixel  <= is_pixel;
			item_s2.tag.use_remap <= remap_enable;
			item_s2.tag.oor       <= is_pixel && remap_enable && !label_in_range;
			item_s2.tag.gray      <= item_s1.gray;
			item_s2.tag.widx      <= item_s1.table_index;
			item_s2.tag.wval      <= item_s1.entry_value[23:0];
			item_s2.label         <= item_s1.label;
		end
	end

	`LHCB_ASSERT_IMPL(a_oor_needs_remap, v_s2 && item_s2.tag.oor, item_s2.tag.use_remap && item_s2.tag.is_pixel)

endmodule

### design/lhcb_hash.sv
// ----------------------------------------------------------------------------
// lhcb_hash
// Golden-ratio multiplicative hash: mask and multiply, then scale to count.
// ----------------------------------------------------------------------------
`include "label_hash_color_blend_unit_assert.svh"

module lhcb_hash
	import lhcb_pkg::*;
#(
	parameter int COLOR_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  cfg_t        cfg,
	input  logic        v_s2,
	input  hash_item_t  item_s2,
	input  logic [31:0] rdata_s2,
	output logic        v_s4,
	output color_item_t item_s4
);

	logic [31:0] sel_label;
	logic [31:0] keyed;
	logic [63:0] frac_full;
	logic [5:0]  n;
	logic [37:0] scaled;

	logic        v_s3;
	tag_t        tag_s3;
	logic [31:0] frac_s3;

	assign sel_label = item_s2.tag.use_remap ? rdata_s2 : item_s2.label;
	assign keyed     = sel_label ^ cfg.hash_mask;
	assign frac_full = 64'(keyed) * 64'(GOLDEN_FRAC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s3  <= item_s2.tag;
			frac_s3 <= frac_full[31:0];
		end
	end

	// count above the colormap depth is clamped
	assign n = ({26'd0, cfg.color_count} > 32'(COLOR_DEPTH)) ? 6'(COLOR_DEPTH)
	                                                      : cfg.color_count;
	assign scaled = 38'(frac_s3) * 38'(n);

	always_ff @(posedge clk) begin
		if (en) begin
			item_s4.tag <= tag_s3;
			item_s4.h   <= scaled[37:32];
		end
	end

	`LHCB_ASSERT_NEXT(a_stall_holds_s4, !en && v_s4, v_s4 && $stable(item_s4.tag.gray))

endmodule

### design/lhcb_color.sv
// ----------------------------------------------------------------------------
// lhcb_color
// Colormap memory: color load writes and registered lookup by hash index.
// ----------------------------------------------------------------------------
module lhcb_color
	import lhcb_pkg::*;
#(
	parameter int COLOR_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        v_s4,
	input  color_item_t item_s4,
	output logic        v_s5,
	output blend_item_t item_s5,
	output logic [23:0] rgb_s5
);

	localparam int CIW = $clog2(COLOR_DEPTH);

	logic [23:0] mem [COLOR_DEPTH];

	logic wr;
	logic rd;

	assign wr = v_s4 && !item_s4.tag.is_pixel
	            && ({16'd0, item_s4.tag.widx} < 32'(COLOR_DEPTH));
	assign rd = v_s4 && item_s4.tag.is_pixel && !item_s4.tag.oor;

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr)
				mem[CIW'(item_s4.tag.widx)] <= item_s4.tag.wval;
			if (rd)
				rgb_s5 <= mem[CIW'(item_s4.h)];
		end
	end

	// color writes retire here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s5 <= 1'b0;
		else if (en)
			v_s5 <= v_s4 && item_s4.tag.is_pixel;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s5.oor  <= item_s4.tag.oor;
			item_s5.gray <= item_s4.tag.gray;
		end
	end

endmodule

### design/lhcb_blend.sv
// ----------------------------------------------------------------------------
// lhcb_blend
// Channel blend (255-gray)*c/255, output register and skid buffer.
// ----------------------------------------------------------------------------
`include "label_hash_color_blend_unit_assert.svh"

module lhcb_blend
	import lhcb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        v_s5,
	input  blend_item_t item_s5,
	input  logic [23:0] rgb_s5,
	output logic        en,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     result
);

	// exact floor(x/255) for x below 65280
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [15:0] t;
		t = x + 16'd1 + {8'd0, x[15:8]};
		return t[15:8];
	endfunction

	logic [7:0]  inv_gray;
	logic        v_s6;
	logic        oor_s6;
	logic [15:0] r_s6;
	logic [15:0] g_s6;
	logic [15:0] b_s6;
	result_t     din;
	result_t     out_q;
	result_t     skid_q;
	logic        out_valid_q;
	logic        skid_v_q;

	assign inv_gray = CHAN_MAX - item_s5.gray;
	assign en       = !skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else if (en)
			v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oor_s6 <= item_s5.oor;
			r_s6   <= 16'(inv_gray) * 16'(rgb_s5[23:16]);
			g_s6   <= 16'(inv_gray) * 16'(rgb_s5[15:8]);
			b_s6   <= 16'(inv_gray) * 16'(rgb_s5[7:0]);
		end
	end

	// out-of-range labels show black
	always_comb begin
		din.oor   = oor_s6;
		din.red   = oor_s6 ? 8'd0 : div255(r_s6);
		din.green = oor_s6 ? 8'd0 : div255(g_s6);
		din.blue  = oor_s6 ? 8'd0 : div255(b_s6);
	end

	// skid takes the incoming item when the output holds a stalled transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (en) begin
			if (out_valid_q && !out_ready) begin
				if (v_s6)
					skid_v_q <= 1'b1;
			end else begin
				out_valid_q <= v_s6;
			end
		end else if (out_ready) begin
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_valid_q && !out_ready) begin
				if (v_s6)
					skid_q <= din;
			end else begin
				out_q <= din;
			end
		end else if (out_ready) begin
			out_q <= skid_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

	`LHCB_ASSERT_IMPL(a_skid_implies_out, skid_v_q, out_valid_q)
	`LHCB_ASSERT_IMPL(a_oor_black, out_valid_q && out_q.oor, out_q.red == 8'd0 && out_q.green == 8'd0 && out_q.blue == 8'd0)

endmodule

### design/label_hash_color_blend_unit.sv
// ----------------------------------------------------------------------------
// label_hash_color_blend_unit
// Pseudocolor overlay of a segment label stream on a grayscale stream.
// ----------------------------------------------------------------------------
// One item is taken per clock while in_ready is high. Table loads travel the
// same pipeline and update the remap table at stage 1 and the colormap at
// stage 4, exactly where pixels read them, so loads and pixels may be freely
// interleaved. Throughput is set by the single write/read port of each table
// memory, used once per item. A two-entry output (register plus skid) keeps
// in_ready registered; it drops only after the sink has held off out_ready
// long enough for the skid to fill. Neither table is cleared: entries read
// before they are written return garbage.
module label_hash_color_blend_unit
	import lhcb_pkg::*;
#(
	parameter int REMAP_DEPTH = 65536,
	parameter int COLOR_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] table_index,
	input  logic [31:0] entry_value,
	input  logic [31:0] label,
	input  logic [7:0]  gray,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic        label_out_of_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	cfg_t        cfg;
	logic        en;
	logic        v_s1;
	in_item_t    item_s1;
	logic        v_s2;
	hash_item_t  item_s2;
	logic [31:0] rdata_s2;
	logic        v_s4;
	color_item_t item_s4;
	logic        v_s5;
	blend_item_t item_s5;
	logic [23:0] rgb_s5;
	result_t     result;
	logic        known_action;

	assign cfg_ready = 1'b1;
	assign in_ready  = en;

	lhcb_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// unused action code is dropped on transfer
	assign known_action = (action == ACT_REMAP_WR) || (action == ACT_COLOR_WR)
	                      || (action == ACT_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en)
			v_s1 <= in_valid && known_action;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_s1.action      <= action;
			item_s1.table_index <= table_index;
			item_s1.entry_value <= entry_value;
			item_s1.label       <= label;
			item_s1.gray        <= gray;
		end
	end

	lhcb_remap #(
		.REMAP_DEPTH (REMAP_DEPTH)
	) u_remap (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.remap_enable (cfg.remap_enable),
		.v_s1         (v_s1),
		.item_s1      (item_s1),
		.v_s2         (v_s2),
		.item_s2      (item_s2),
		.rdata_s2     (rdata_s2)
	);

	lhcb_hash #(
		.COLOR_DEPTH (COLOR_DEPTH)
	) u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg),
		.v_s2     (v_s2),
		.item_s2  (item_s2),
		.rdata_s2 (rdata_s2),
		.v_s4     (v_s4),
		.item_s4  (item_s4)
	);

	lhcb_color #(
		.COLOR_DEPTH (COLOR_DEPTH)
	) u_color (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.v_s4    (v_s4),
		.item_s4 (item_s4),
		.v_s5    (v_s5),
		.item_s5 (item_s5),
		.rgb_s5  (rgb_s5)
	);

	lhcb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_s5      (v_s5),
		.item_s5   (item_s5),
		.rgb_s5    (rgb_s5),
		.en        (en),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result    (result)
	);

	assign red                = result.red;
	assign green              = result.green;
	assign blue               = result.blue;
	assign label_out_of_range = result.oor;

endmodule
